### sv/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion pipeline.
// No dependencies.
package rmq_pkg;

	localparam int FIELD_W = 18;
	localparam int DIFF_W  = 19;
	localparam int LANES   = 4;
	localparam int SAT_POS = 131071;
	localparam int SAT_NEG = 131072;

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_X     = 2'd1,
		BR_Y     = 2'd2,
		BR_Z     = 2'd3
	} branch_t;

endpackage

### sv/rmq_sqrt_cell.sv
// One cell of the square root chain: resolves one root bit from two radicand bits.
// Standalone; chained by rotation_matrix_to_quaternion.
module rmq_sqrt_cell #(
	parameter int XW = 48,
	parameter int RW = 24,
	parameter int TW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          prv_vld,
	input  logic [XW-1:0] prv_x,
	input  logic [RW:0]   prv_rem,
	input  logic [RW-1:0] prv_root,
	input  logic [TW-1:0] prv_tag,
	output logic          vld_q,
	output logic [XW-1:0] x_q,
	output logic [RW:0]   rem_q,
	output logic [RW-1:0] root_q,
	output logic [TW-1:0] tag_q
);

	logic [RW+2:0] t;
	logic [RW+2:0] trial;
	logic          ge;

	always_comb begin
		t     = {prv_rem, prv_x[XW-1 -: 2]};
		trial = {1'b0, prv_root, 2'b01};
		ge    = (t >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= prv_vld;
		end
	end

	always_ff @(posedge clk) begin
		x_q    <= {prv_x[XW-3:0], 2'b00};
		rem_q  <= ge ? (RW+1)'(t - trial) : (RW+1)'(t);
		root_q <= {prv_root[RW-2:0], ge};
		tag_q  <= prv_tag;
	end

endmodule

### sv/rmq_div_cell.sv
// One cell of the divider chain: one quotient bit for each of the four lanes.
// Uses rmq_pkg; chained by rotation_matrix_to_quaternion.
module rmq_div_cell #(
	parameter int NW = 36,
	parameter int DW = 25,
	parameter int TW = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                prv_vld,
	input  logic [DW-1:0]                       prv_d,
	input  logic [rmq_pkg::LANES-1:0][NW-1:0]   prv_num,
	input  logic [rmq_pkg::LANES-1:0][DW-1:0]   prv_rem,
	input  logic [TW-1:0]                       prv_tag,
	output logic                                vld_q,
	output logic [DW-1:0]                       d_q,
	output logic [rmq_pkg::LANES-1:0][NW-1:0]   num_q,
	output logic [rmq_pkg::LANES-1:0][DW-1:0]   rem_q,
	output logic [TW-1:0]                       tag_q
);

	logic [rmq_pkg::LANES-1:0][DW:0]   t;
	logic [rmq_pkg::LANES-1:0]         ge;
	logic [rmq_pkg::LANES-1:0][DW-1:0] rem_n;
	logic [rmq_pkg::LANES-1:0][NW-1:0] num_n;

	always_comb begin
		for (int l = 0; l < rmq_pkg::LANES; l++) begin
			t[l]     = {prv_rem[l], prv_num[l][NW-1]};
			ge[l]    = (t[l] >= {1'b0, prv_d});
			rem_n[l] = ge[l] ? DW'(t[l] - {1'b0, prv_d}) : DW'(t[l]);
			num_n[l] = {prv_num[l][NW-2:0], ge[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= prv_vld;
		end
	end

	always_ff @(posedge clk) begin
		d_q   <= prv_d;
		num_q <= num_n;
		rem_q <= rem_n;
		tag_q <= prv_tag;
	end

endmodule

### sv/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion, Shepperd branch selection, fully pipelined.
// The pipeline is an input register, the square root cells (one per root bit), a divider set-up
// register, the divider cells (one per quotient bit) and an output register.
// Throughput: one matrix per cycle; busy stays low, done strobes for one cycle per result.
// Reset clears only the valid bits of the pipeline; uses rmq_pkg, rmq_sqrt_cell, rmq_div_cell.
module rotation_matrix_to_quaternion #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [17:0] m00,
	input  logic signed [17:0] m01,
	input  logic signed [17:0] m02,
	input  logic signed [17:0] m10,
	input  logic signed [17:0] m11,
	input  logic signed [17:0] m12,
	input  logic signed [17:0] m20,
	input  logic signed [17:0] m21,
	input  logic signed [17:0] m22,
	output logic               done,
	output logic signed [17:0] quat_w,
	output logic signed [17:0] quat_x,
	output logic signed [17:0] quat_y,
	output logic signed [17:0] quat_z,
	output logic [1:0]         branch_used,
	output logic               invalid
);

	localparam int LN  = rmq_pkg::LANES;
	localparam int NDW = rmq_pkg::DIFF_W;
	localparam int RW  = (32 + FRAC_BITS) / 2;
	localparam int SQW = 2 * RW;
	localparam int DW  = RW + 1;
	localparam int NW  = FRAC_BITS + 20;
	localparam int T1W = 3 + LN * NDW;
	localparam int T2W = 3 + LN + RW;
	localparam logic [NW-1:0] ONE_N = NW'(1) << FRAC_BITS;
	localparam logic [NW-1:0] LIM_P = (FRAC_BITS >= 17) ? NW'(rmq_pkg::SAT_POS) : ONE_N;
	localparam logic [NW-1:0] LIM_N = (FRAC_BITS >= 17) ? NW'(rmq_pkg::SAT_NEG) : ONE_N;
	localparam logic signed [31:0] ONE_A = 32'sd1 <<< FRAC_BITS;

	assign busy = 1'b0;

	// front end: branch, square root argument, numerators
	rmq_pkg::branch_t        br;
	logic signed [19:0]      trace;
	logic signed [31:0]      arg;
	logic [LN-1:0][NDW-1:0]  num;
	logic signed [NDW-1:0]   d_zy, d_xz, d_yx, s_xy, s_xz, s_yz;
	logic                    bad;

	always_comb begin
		trace = 20'(m00) + 20'(m11) + 20'(m22);
		d_zy  = NDW'(m21) - NDW'(m12);
		d_xz  = NDW'(m02) - NDW'(m20);
		d_yx  = NDW'(m10) - NDW'(m01);
		s_xy  = NDW'(m01) + NDW'(m10);
		s_xz  = NDW'(m02) + NDW'(m20);
		s_yz  = NDW'(m12) + NDW'(m21);
		num   = '0;
		if (trace > 20'sd0) begin
			br     = rmq_pkg::BR_TRACE;
			arg    = ONE_A + 32'(trace);
			num[1] = d_zy;
			num[2] = d_xz;
			num[3] = d_yx;
		end else if (m00 > m11 && m00 > m22) begin
			br     = rmq_pkg::BR_X;
			arg    = ONE_A + 32'(m00) - 32'(m11) - 32'(m22);
			num[0] = d_zy;
			num[2] = s_xy;
			num[3] = s_xz;
		end else if (m11 > m22) begin
			br     = rmq_pkg::BR_Y;
			arg    = ONE_A + 32'(m11) - 32'(m00) - 32'(m22);
			num[0] = d_xz;
			num[1] = s_xy;
			num[3] = s_yz;
		end else begin
			br     = rmq_pkg::BR_Z;
			arg    = ONE_A + 32'(m22) - 32'(m00) - 32'(m11);
			num[0] = d_yx;
			num[1] = s_xz;
			num[2] = s_yz;
		end
		bad = (arg <= 32'sd0);
	end

	logic                sq_vld  [RW+1];
	logic [SQW-1:0]      sq_x    [RW+1];
	logic [RW:0]         sq_rem  [RW+1];
	logic [RW-1:0]       sq_root [RW+1];
	logic [T1W-1:0]      sq_tag  [RW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld[0] <= 1'b0;
		end else begin
			sq_vld[0] <= start;
		end
	end

	always_ff @(posedge clk) begin
		sq_x[0]    <= bad ? '0 : SQW'({arg[30:0], {FRAC_BITS{1'b0}}});
		sq_rem[0]  <= '0;
		sq_root[0] <= '0;
		sq_tag[0]  <= {br, bad, num};
	end

	for (genvar i = 0; i < RW; i++) begin : g_sqrt
		rmq_sqrt_cell #(.XW(SQW), .RW(RW), .TW(T1W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.prv_vld  (sq_vld[i]),
			.prv_x    (sq_x[i]),
			.prv_rem  (sq_rem[i]),
			.prv_root (sq_root[i]),
			.prv_tag  (sq_tag[i]),
			.vld_q    (sq_vld[i+1]),
			.x_q      (sq_x[i+1]),
			.rem_q    (sq_rem[i+1]),
			.root_q   (sq_root[i+1]),
			.tag_q    (sq_tag[i+1])
		);
	end

	// divider set-up: magnitudes with rounding offset, divisor 2r
	logic [LN-1:0][NDW-1:0] num2;
	logic [LN-1:0][NW-1:0]  dvn;
	logic [LN-1:0]          sgn;
	logic [RW-1:0]          r_fin;

	always_comb begin
		num2  = sq_tag[RW][LN*NDW-1:0];
		r_fin = sq_root[RW];
		for (int l = 0; l < LN; l++) begin
			sgn[l] = num2[l][NDW-1];
			dvn[l] = NW'({(sgn[l] ? NDW'(-num2[l]) : num2[l]), {FRAC_BITS{1'b0}}})
				+ NW'(r_fin);
		end
	end

	logic                   dv_vld [NW+1];
	logic [DW-1:0]          dv_d   [NW+1];
	logic [LN-1:0][NW-1:0]  dv_num [NW+1];
	logic [LN-1:0][DW-1:0]  dv_rem [NW+1];
	logic [T2W-1:0]         dv_tag [NW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld[0] <= 1'b0;
		end else begin
			dv_vld[0] <= sq_vld[RW];
		end
	end

	always_ff @(posedge clk) begin
		dv_d[0]   <= {r_fin, 1'b0};
		dv_num[0] <= dvn;
		dv_rem[0] <= '0;
		dv_tag[0] <= {sq_tag[RW][T1W-1 -: 3], sgn, r_fin};
	end

	for (genvar j = 0; j < NW; j++) begin : g_div
		rmq_div_cell #(.NW(NW), .DW(DW), .TW(T2W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.prv_vld (dv_vld[j]),
			.prv_d   (dv_d[j]),
			.prv_num (dv_num[j]),
			.prv_rem (dv_rem[j]),
			.prv_tag (dv_tag[j]),
			.vld_q   (dv_vld[j+1]),
			.d_q     (dv_d[j+1]),
			.num_q   (dv_num[j+1]),
			.rem_q   (dv_rem[j+1]),
			.tag_q   (dv_tag[j+1])
		);
	end

	// output: dominant lane, saturation, invalid zeroing
	logic [1:0]            o_br;
	logic                  o_bad;
	logic [LN-1:0]         o_sgn;
	logic [RW-1:0]         o_r;
	logic [NW-1:0]         o_dom;
	logic [LN-1:0][NW-1:0] mag;
	logic [LN-1:0][17:0]   res;
	logic [NW-1:0]         lim;
	logic [NW-1:0]         mc;

	always_comb begin
		o_br  = dv_tag[NW][T2W-1 -: 2];
		o_bad = dv_tag[NW][T2W-3];
		o_sgn = dv_tag[NW][RW +: LN];
		o_r   = dv_tag[NW][RW-1:0];
		o_dom = NW'(({1'b0, o_r} + (RW+1)'(1)) >> 1);
		for (int l = 0; l < LN; l++) begin
			mag[l] = (o_br == 2'(l)) ? o_dom : dv_num[NW][l];
			lim    = o_sgn[l] ? LIM_N : LIM_P;
			mc     = (mag[l] > lim) ? lim : mag[l];
			res[l] = o_bad ? 18'd0 : (o_sgn[l] ? 18'(-mc[17:0]) : mc[17:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_vld[NW];
		end
	end

	always_ff @(posedge clk) begin
		quat_w      <= res[0];
		quat_x      <= res[1];
		quat_y      <= res[2];
		quat_z      <= res[3];
		branch_used <= o_br;
		invalid     <= o_bad;
	end

endmodule
